/* design/salt_pkg.sv */
package salt_pkg;

    // Rule table size and fixed-point format
    localparam int NUM_RULES = 5;
    localparam int FRAC_BITS = 8;
    localparam int ROM_LEN   = 5;
    localparam int RULE_CNT  = (NUM_RULES < ROM_LEN) ? NUM_RULES : ROM_LEN;
    localparam int IDX_W     = (RULE_CNT > 1) ? $clog2(RULE_CNT) : 1;

    // Data type codes
    localparam logic [2:0] DT_FLOAT32 = 3'd0;
    localparam logic [2:0] DT_INT32   = 3'd1;
    localparam logic [2:0] DT_DOUBLE  = 3'd2;
    localparam logic [2:0] DT_INT     = 3'd3;
    localparam logic [2:0] DT_CHAR    = 3'd4;
    localparam logic [2:0] DT_NONE    = 3'd7;

    // Alarm levels
    localparam logic [1:0] LVL_NORMAL = 2'd0;
    localparam logic [1:0] LVL_WARN   = 2'd1;
    localparam logic [1:0] LVL_CRIT   = 2'd2;

    typedef struct packed {
        logic [7:0]         slave;
        logic [7:0]         id;
        logic [7:0]         stype;
        logic [2:0]         dtype;
        logic signed [31:0] warn_lo;
        logic signed [31:0] warn_hi;
        logic signed [31:0] crit_lo;
        logic signed [31:0] crit_hi;
    } t_rule;

    typedef struct packed {
        logic             load_in;
        logic             decode;
        logic             convert;
        logic             emit;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic dtype_ok;
        logic hit;
        logic changed;
        logic out_busy;
    } t_stat;

    function automatic logic signed [31:0] scl(input int x);
        scl = 32'(x <<< FRAC_BITS);
    endfunction

    function automatic t_rule mk_rule(input logic [7:0] slave, input logic [7:0] id,
                                      input logic [7:0] stype, input logic [2:0] dtype,
                                      input int wlo, input int whi,
                                      input int clo, input int chi);
        t_rule r;
        r.slave   = slave;
        r.id      = id;
        r.stype   = stype;
        r.dtype   = dtype;
        r.warn_lo = scl(wlo);
        r.warn_hi = scl(whi);
        r.crit_lo = scl(clo);
        r.crit_hi = scl(chi);
        mk_rule   = r;
    endfunction

    function automatic t_rule rule_rom(input logic [IDX_W-1:0] idx);
        case (int'(idx))
            0:       rule_rom = mk_rule(8'h01, 8'd1, 8'd0, DT_INT,     10, 1500, 5, 2000);
            1:       rule_rom = mk_rule(8'h01, 8'd2, 8'd1, DT_INT32,   10, 3000, 5, 4000);
            2:       rule_rom = mk_rule(8'h02, 8'd1, 8'd2, DT_FLOAT32, 10, 30,   5, 50);
            3:       rule_rom = mk_rule(8'h02, 8'd2, 8'd3, DT_INT,     10, 100,  5, 200);
            4:       rule_rom = mk_rule(8'h02, 8'd3, 8'd4, DT_FLOAT32, 10, 1500, 5, 2000);
            default: rule_rom = mk_rule(8'hFF, 8'hFF, 8'hFF, DT_NONE, 0, 0, 0, 0);
        endcase
    endfunction

endpackage

/* design/sensor_alarm_level_tracker_top.sv */
// An input transaction is captured, decoded, converted and then checked rule by rule up to
//   the matching rule; one reading is handled at a time, and an invalid data type ends after
//   decode. A result goes to m_axis only when the matched rule's level changes; a result
//   still held on m_axis stalls the scan and so the next reading.
// Reset: synchronous active-low i_rst_n clears the controller, the output valid and
//   every stored rule level to normal; ready to accept the cycle after reset.
module sensor_alarm_level_tracker_top import salt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input reading stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // slave_addr[7:0], sensor_id[15:8],
                                       // sensor_type[23:16], reading_bits[87:24]
    input  logic [2:0]  s_axis_tuser,  // data_type[2:0]
    // Alarm level change stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,  // rule_index[2:0], ev_slave_addr[10:3],
                                       // ev_sensor_id[18:11], ev_sensor_type[26:19],
                                       // level[28:27], ev_reading[92:29], zero[95:93]
    output logic [2:0]  m_axis_tuser   // ev_data_type[2:0]
);

    // Controller sequences capture, decode, convert and a rule-by-rule scan;
    // the datapath holds the reading, the fixed-point value, the per-rule
    // levels and the output register. The output register lets a new
    // reading be taken while a result waits for the downstream side.
    t_cmd  w_cmd;
    t_stat w_stat;

    salt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    salt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .i_in_dtype  (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_dtype (m_axis_tuser)
    );

endmodule

/* design/salt_ctrl.sv */
module salt_ctrl import salt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_CONVERT,
        S_SCAN
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RULE_CNT - 1);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        o_cmd         = '0;
        o_cmd.idx     = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = i_stat.dtype_ok ? S_CONVERT : S_IDLE;
            end
            S_CONVERT: begin
                o_cmd.convert = 1'b1;
                n_idx         = '0;
                n_state       = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    if (!i_stat.changed) begin
                        n_state = S_IDLE;
                    end else if (!i_stat.out_busy) begin
                        o_cmd.emit = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= LAST_IDX))
        else $error("rule scan index beyond table");
    a_emit_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after a result");
    a_scan_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONVERT) |=> (r_state == S_SCAN && r_idx == '0))
        else $error("rule scan did not start at the first rule");
`endif

endmodule

/* design/salt_dp.sv */
module salt_dp import salt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [87:0] i_in_data,
    input  logic [2:0]  i_in_dtype,
    input  logic        i_out_ready,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_out_valid,
    output logic [95:0] o_out_data,
    output logic [2:0]  o_out_dtype
);

    // Captured transaction
    logic [7:0]  r_slave, r_id, r_type;
    logic [2:0]  r_dtype;
    logic [63:0] r_bits;

    // Decoded operand
    logic [52:0]        r_mant, n_mant;
    logic signed [12:0] r_sh, n_sh;
    logic               r_neg, n_neg;
    logic               r_nan, n_nan;
    logic               r_inf, n_inf;
    logic               r_is_int, n_is_int;
    logic signed [31:0] r_int_val, n_int_val;

    // Fixed-point value
    logic signed [31:0] r_value, n_value;

    // Per-rule level and output register
    logic [1:0]  r_level [RULE_CNT];
    logic        r_out_valid;
    logic [IDX_W-1:0] r_out_index;
    logic [7:0]  r_out_slave, r_out_id, r_out_type;
    logic [1:0]  r_out_level;
    logic [2:0]  r_out_dtype;
    logic [63:0] r_out_reading;

    // ---------------- decode ----------------
    logic [7:0]         w_e8;
    logic [10:0]        w_e11;
    logic signed [31:0] w_s;
    logic signed [47:0] w_sw;

    always_comb begin
        w_e8      = r_bits[30:23];
        w_e11     = r_bits[62:52];
        w_s       = (r_dtype == DT_CHAR) ? $signed({24'b0, r_bits[7:0]}) : $signed(r_bits[31:0]);
        w_sw      = 48'(w_s) <<< FRAC_BITS;
        n_mant    = '0;
        n_sh      = '0;
        n_neg     = 1'b0;
        n_nan     = 1'b0;
        n_inf     = 1'b0;
        n_is_int  = 1'b0;
        if (w_sw > 48'sd2147483647) begin
            n_int_val = 32'sh7FFF_FFFF;
        end else if (w_sw < -48'sd2147483648) begin
            n_int_val = 32'sh8000_0000;
        end else begin
            n_int_val = w_sw[31:0];
        end
        case (r_dtype)
            DT_FLOAT32: begin
                n_neg = r_bits[31];
                if (w_e8 == 8'hFF) begin
                    n_nan = (r_bits[22:0] != '0);
                    n_inf = (r_bits[22:0] == '0);
                end else if (w_e8 == 8'h00) begin
                    n_mant = {30'b0, r_bits[22:0]};
                    n_sh   = -13'sd149 + 13'(FRAC_BITS);
                end else begin
                    n_mant = {29'b0, 1'b1, r_bits[22:0]};
                    n_sh   = $signed({5'b0, w_e8}) - 13'sd150 + 13'(FRAC_BITS);
                end
            end
            DT_DOUBLE: begin
                n_neg = r_bits[63];
                if (w_e11 == 11'h7FF) begin
                    n_nan = (r_bits[51:0] != '0);
                    n_inf = (r_bits[51:0] == '0);
                end else if (w_e11 == 11'h000) begin
                    n_mant = {1'b0, r_bits[51:0]};
                    n_sh   = -13'sd1074 + 13'(FRAC_BITS);
                end else begin
                    n_mant = {1'b1, r_bits[51:0]};
                    n_sh   = $signed({2'b0, w_e11}) - 13'sd1075 + 13'(FRAC_BITS);
                end
            end
            DT_INT32, DT_INT, DT_CHAR: n_is_int = 1'b1;
            default: n_is_int = 1'b0;
        endcase
    end

    // ---------------- convert ----------------
    logic [95:0]        w_left;
    logic signed [12:0] w_nsh;
    logic [52:0]        w_right;
    logic [31:0]        w_mag;

    always_comb begin
        w_left  = {43'b0, r_mant} << r_sh[4:0];
        w_nsh   = -r_sh;
        w_right = r_mant >> w_nsh[5:0];
        if (r_mant == '0) begin
            w_mag = '0;
        end else if (!r_sh[12]) begin
            // left shift: saturate once the magnitude reaches 2^31
            if (r_sh >= 13'sd32 || (|w_left[95:31])) w_mag = 32'h8000_0000;
            else                                     w_mag = w_left[31:0];
        end else if (w_nsh >= 13'sd64) begin
            w_mag = '0;
        end else if ((|w_right[52:32]) || (w_right[31] && (|w_right[30:0]))) begin
            w_mag = 32'h8000_0000;
        end else begin
            w_mag = w_right[31:0];
        end

        if (r_is_int) begin
            n_value = r_int_val;
        end else if (r_inf) begin
            n_value = r_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (r_neg) begin
            n_value = -$signed(w_mag);
        end else begin
            n_value = w_mag[31] ? 32'sh7FFF_FFFF : $signed(w_mag);
        end
    end

    // ---------------- rule scan ----------------
    t_rule      w_rule;
    logic [1:0] w_lvl;

    always_comb begin
        w_rule = rule_rom(i_cmd.idx);
        if (r_nan) begin
            w_lvl = LVL_NORMAL;
        end else if (r_value <= w_rule.crit_lo || r_value >= w_rule.crit_hi) begin
            w_lvl = LVL_CRIT;
        end else if (r_value <= w_rule.warn_lo || r_value >= w_rule.warn_hi) begin
            w_lvl = LVL_WARN;
        end else begin
            w_lvl = LVL_NORMAL;
        end
        o_stat.dtype_ok = (r_dtype <= DT_CHAR);
        o_stat.hit      = (w_rule.slave == r_slave) && (w_rule.id == r_id) &&
                          (w_rule.stype == r_type) && (w_rule.dtype == r_dtype);
        o_stat.changed  = (w_lvl != r_level[i_cmd.idx]);
        o_stat.out_busy = r_out_valid && !i_out_ready;
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_slave <= i_in_data[7:0];
            r_id    <= i_in_data[15:8];
            r_type  <= i_in_data[23:16];
            r_bits  <= i_in_data[87:24];
        end
        if (i_cmd.decode) begin
            r_mant    <= n_mant;
            r_sh      <= n_sh;
            r_neg     <= n_neg;
            r_nan     <= n_nan;
            r_inf     <= n_inf;
            r_is_int  <= n_is_int;
            r_int_val <= n_int_val;
        end
        if (i_cmd.convert) begin
            r_value <= n_value;
        end
        if (i_cmd.emit) begin
            r_out_index   <= i_cmd.idx;
            r_out_slave   <= r_slave;
            r_out_id      <= r_id;
            r_out_type    <= r_type;
            r_out_level   <= w_lvl;
            r_out_dtype   <= r_dtype;
            r_out_reading <= r_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dtype     <= DT_NONE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < RULE_CNT; i++) begin
                r_level[i] <= LVL_NORMAL;
            end
        end else begin
            if (i_cmd.load_in) begin
                r_dtype <= i_in_dtype;
            end
            r_out_valid <= i_cmd.emit || (r_out_valid && !i_out_ready);
            if (i_cmd.emit) begin
                r_level[i_cmd.idx] <= w_lvl;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {3'b0, r_out_reading, r_out_level, r_out_type, r_out_id,
                          r_out_slave, 3'(r_out_index)};
    assign o_out_dtype = r_out_dtype;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !(r_out_valid && !i_out_ready))
        else $error("result register overwritten while held");
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_out_valid && r_out_level == r_level[r_out_index]))
        else $error("result level differs from stored rule level");
    a_level_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_level != 2'b11))
        else $error("unused level code on output");
`endif

endmodule
